### sv/prp_pkg.sv
package prp_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd1;

	localparam logic [1:0] POL_FIFO  = 2'd0;
	localparam logic [1:0] POL_CLOCK = 2'd1;
	localparam logic [1:0] POL_LRU   = 2'd2;

	localparam logic [3:0] FRAME_COUNT_RESET = 4'd8;

	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] page_number;
	} prp_req_t;

	typedef struct packed {
		logic        hit;
		logic        fault;
		logic        cold_fill;
		logic [2:0]  frame_index;
		logic [15:0] evicted_page;
		logic [31:0] fault_count;
	} prp_rsp_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic sweep;
		logic vread;
		logic commit;
	} prp_cmd_t;

	typedef struct packed {
		logic clear;
		logic scan_done;
		logic found;
		logic full;
		logic clock;
		logic sweep_free;
		logic out_free;
	} prp_sts_t;

endpackage

### sv/prp_ctrl.sv
module prp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  prp_pkg::prp_sts_t  sts,
	output prp_pkg::prp_cmd_t  cmd
);
	import prp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_VREAD,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						if (sts.clear || sts.found || !sts.full || !sts.clock) begin
							state_q <= ST_COMMIT;
						end else begin
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					if (sts.sweep_free) begin
						state_q <= ST_VREAD;
					end
				end
				ST_VREAD: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall  = (state_q != ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) && req_valid;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.sweep  = (state_q == ST_SWEEP);
	assign cmd.vread  = (state_q == ST_VREAD);
	assign cmd.commit = (state_q == ST_COMMIT) && sts.out_free;

endmodule

### sv/prp_dp.sv
module prp_dp #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  prp_pkg::prp_cmd_t                 cmd,
	output prp_pkg::prp_sts_t                 sts,
	input  prp_pkg::prp_req_t                 req_data,
	input  logic                              rsp_stall,
	output logic                              rsp_valid,
	output prp_pkg::prp_rsp_t                 rsp_data,
	input  logic                              cfg_we,
	input  logic [prp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import prp_pkg::*;

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);

	logic [PAGE_BITS-1:0] page_mem [FRAMES];
	logic [31:0]          stamp_mem [FRAMES];

	logic [1:0]           policy_q;
	logic [3:0]           frames_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 clear_q;
	logic [CW-1:0]        res_q;
	logic [FW-1:0]        hand_q;
	logic [31:0]          ref_q;
	logic [31:0]          fault_q;
	logic [FRAMES-1:0]    use_q;
	logic [CW-1:0]        scan_q;
	logic                 rv_s1;
	logic [FW-1:0]        ridx_s1;
	logic [PAGE_BITS-1:0] rd_page_q;
	logic [31:0]          rd_stamp_q;
	logic                 found_q;
	logic [FW-1:0]        found_idx_q;
	logic [FW-1:0]        min_idx_q;
	logic [31:0]          min_stamp_q;
	logic [PAGE_BITS-1:0] min_page_q;
	logic [FW-1:0]        victim_q;
	logic                 rsp_valid_q;
	prp_rsp_t             rsp_q;

	logic [CW-1:0]        eff_w;
	logic                 full_w;
	logic                 clock_w;
	logic                 scan_lt;
	logic [FW-1:0]        h_cur;
	logic [FW-1:0]        hand_nx;
	logic                 rd_en;
	logic [FW-1:0]        rd_addr;
	logic [FW-1:0]        frame_w;
	logic                 pg_we;
	logic                 st_we;
	logic [31:0]          fault_nx;
	prp_rsp_t             res_w;
	logic                 out_free;

	always_comb begin
		if (frames_q == '0) begin
			eff_w = CW'(1);
		end else if (int'(frames_q) > FRAMES) begin
			eff_w = CW'(FRAMES);
		end else begin
			eff_w = CW'(frames_q);
		end
	end

	assign full_w   = (res_q >= eff_w);
	assign clock_w  = (policy_q == POL_CLOCK);
	assign scan_lt  = (scan_q < res_q);
	assign h_cur    = (CW'(hand_q) >= res_q) ? '0 : hand_q;
	assign hand_nx  = ((CW'(h_cur) + CW'(1)) >= res_q) ? '0 : (h_cur + FW'(1));
	assign rd_en    = (cmd.scan && scan_lt) || cmd.vread;
	assign rd_addr  = cmd.vread ? victim_q : scan_q[FW-1:0];
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		res_w    = '0;
		frame_w  = '0;
		pg_we    = 1'b0;
		st_we    = 1'b0;
		fault_nx = fault_q;
		if (clear_q) begin
			res_w = '0;
		end else if (found_q) begin
			frame_w   = found_idx_q;
			res_w.hit = 1'b1;
			st_we     = (policy_q == POL_CLOCK) || (policy_q == POL_LRU);
		end else if (!full_w) begin
			frame_w         = res_q[FW-1:0];
			res_w.cold_fill = 1'b1;
			pg_we           = 1'b1;
			st_we           = 1'b1;
		end else begin
			frame_w            = clock_w ? victim_q : min_idx_q;
			res_w.fault        = 1'b1;
			res_w.evicted_page = 16'(clock_w ? rd_page_q : min_page_q);
			pg_we              = 1'b1;
			st_we              = 1'b1;
			if (fault_q != '1) begin
				fault_nx = fault_q + 32'd1;
			end
		end
		if (!clear_q) begin
			res_w.frame_index = 3'(frame_w);
			res_w.fault_count = fault_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && pg_we) begin
			page_mem[frame_w] <= page_q;
		end
		if (cmd.commit && st_we) begin
			stamp_mem[frame_w] <= ref_q;
		end
		if (rd_en) begin
			rd_page_q  <= page_mem[rd_addr];
			rd_stamp_q <= stamp_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_FIFO;
			frames_q    <= FRAME_COUNT_RESET;
			res_q       <= '0;
			hand_q      <= '0;
			ref_q       <= '0;
			fault_q     <= '0;
			use_q       <= '0;
			scan_q      <= '0;
			rv_s1       <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_POLICY) begin
				policy_q <= cfg_data[1:0];
			end else if (cfg_we && cfg_index == REG_FRAME_COUNT) begin
				frames_q <= cfg_data;
			end

			rv_s1 <= cmd.scan && scan_lt;
			if (cmd.load) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan && scan_lt) begin
					scan_q <= scan_q + CW'(1);
				end
				if (rv_s1 && rd_page_q == page_q) begin
					found_q <= 1'b1;
				end
			end

			if (cmd.sweep) begin
				if (use_q[h_cur]) begin
					use_q[h_cur] <= 1'b0;
				end
				hand_q <= hand_nx;
			end

			if (cmd.commit) begin
				if (clear_q) begin
					use_q   <= '0;
					res_q   <= '0;
					hand_q  <= '0;
					ref_q   <= '0;
					fault_q <= '0;
				end else begin
					use_q[frame_w] <= 1'b1;
					if (!found_q && !full_w) begin
						res_q <= res_q + CW'(1);
					end
					fault_q <= fault_nx;
					if (ref_q != '1) begin
						ref_q <= ref_q + 32'd1;
					end
				end
			end

			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q  <= PAGE_BITS'(req_data.page_number);
			clear_q <= (req_data.action == ACT_CLEAR);
		end
		ridx_s1 <= scan_q[FW-1:0];
		if (!cmd.load && rv_s1 && !found_q && rd_page_q == page_q) begin
			found_idx_q <= ridx_s1;
		end
		if (rv_s1 && (ridx_s1 == '0 || rd_stamp_q < min_stamp_q)) begin
			min_idx_q   <= ridx_s1;
			min_stamp_q <= rd_stamp_q;
			min_page_q  <= rd_page_q;
		end
		if (cmd.sweep && !use_q[h_cur]) begin
			victim_q <= h_cur;
		end
		if (cmd.commit) begin
			rsp_q <= res_w;
		end
	end

	assign sts.clear      = clear_q;
	assign sts.scan_done  = !scan_lt && !rv_s1;
	assign sts.found      = found_q;
	assign sts.full       = full_w;
	assign sts.clock      = clock_w;
	assign sts.sweep_free = !use_q[h_cur];
	assign sts.out_free   = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

### sv/page_replacement_policy.sv
// Time from request to result is set by the scan of the frame table,
// which is read through its single registered read port.
// A CLOCK fault adds a sweep of the use bits to find the victim and a read of the victim.
// One request is in work at a time; the next is taken the cycle after its result is registered.
// Asynchronous reset clears the counters, use bits and hand and sets FIFO with eight frames;
// the page and stamp table is not cleared, since only resident entries are ever read.
module page_replacement_policy #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  prp_pkg::prp_req_t                 req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output prp_pkg::prp_rsp_t                 rsp_data,
	input  logic                              cfg_we,
	input  logic [prp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import prp_pkg::*;

	prp_cmd_t cmd;
	prp_sts_t sts;

	prp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	prp_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

### sv/prp_checker.sv
module prp_sva (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input prp_pkg::prp_rsp_t rsp_data
);
	import prp_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed or dropped");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $countones({rsp_data.hit, rsp_data.fault, rsp_data.cold_fill}) <= 1)
		else $error("result is more than one of hit, fault and cold fill");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.fault |-> rsp_data.evicted_page == '0)
		else $error("evicted page set without a fault");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.fault |-> rsp_data.fault_count != '0)
		else $error("fault reported with a zero fault count");

endmodule

bind page_replacement_policy prp_sva u_prp_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

### tb/prp_checker.sv
`timescale 1ns / 1ps

module prp_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  prp_pkg::prp_req_t              req_data,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  prp_pkg::prp_rsp_t              rsp_data,
	input  logic                           cfg_we,
	input  logic [prp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             results_seen
);
	import prp_pkg::*;

	localparam int TABLE_DEPTH = 8;

	logic [1:0]  policy_q;
	logic [3:0]  frames_q;
	logic [15:0] page_tab [TABLE_DEPTH];
	logic [31:0] stamp_tab [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] used;
	int unsigned resident;
	int unsigned hand;
	logic [31:0] ref_cnt;
	logic [31:0] fault_cnt;
	prp_rsp_t    expected_q [$];
	int          fails;
	int          seen_count;

	function automatic void clear_table();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			page_tab[i] = '0;
			stamp_tab[i] = '0;
		end
		used = '0;
		resident = 0;
		hand = 0;
		ref_cnt = '0;
		fault_cnt = '0;
	endfunction

	function automatic int unsigned clock_victim();
		int unsigned n;
		int unsigned h;
		n = (resident > TABLE_DEPTH) ? TABLE_DEPTH : resident;
		if (n == 0)
			n = 1;
		h = hand;
		if (h >= n)
			h = 0;
		for (int unsigned k = 0; k <= n; k++) begin
			if (!used[h])
				break;
			used[h] = 1'b0;
			h = (h + 1 >= n) ? 0 : h + 1;
		end
		hand = (h + 1 >= n) ? 0 : h + 1;
		return h;
	endfunction

	function automatic prp_rsp_t predict_access(prp_req_t r);
		prp_rsp_t    res;
		int unsigned limit;
		int unsigned slot;
		logic [31:0] stamp;
		logic        found;
		res = '0;
		if (r.action == ACT_CLEAR) begin
			clear_table();
			return res;
		end
		stamp = ref_cnt;
		found = 1'b0;
		slot = 0;
		for (int unsigned i = 0; i < resident && i < TABLE_DEPTH; i++) begin
			if (!found && page_tab[i] == r.page_number) begin
				found = 1'b1;
				slot = i;
			end
		end
		limit = (frames_q == 0) ? 1 : ((frames_q > TABLE_DEPTH) ? TABLE_DEPTH : frames_q);
		if (found) begin
			res.hit = 1'b1;
			used[slot] = 1'b1;
			if (policy_q == POL_CLOCK || policy_q == POL_LRU)
				stamp_tab[slot] = stamp;
		end else if (resident < limit) begin
			res.cold_fill = 1'b1;
			slot = resident;
			resident++;
		end else begin
			res.fault = 1'b1;
			if (policy_q == POL_CLOCK) begin
				slot = clock_victim();
			end else begin
				slot = 0;
				for (int unsigned i = 1; i < resident && i < TABLE_DEPTH; i++) begin
					if (stamp_tab[i] < stamp_tab[slot])
						slot = i;
				end
			end
			res.evicted_page = page_tab[slot];
			if (fault_cnt != '1)
				fault_cnt++;
		end
		if (!found) begin
			page_tab[slot] = r.page_number;
			stamp_tab[slot] = stamp;
			used[slot] = 1'b1;
		end
		if (ref_cnt != '1)
			ref_cnt++;
		res.frame_index = 3'(slot);
		res.fault_count = fault_cnt;
		return res;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic check_result(prp_rsp_t got);
		prp_rsp_t want;
		if (expected_q.size() == 0) begin
			fails++;
			$display("%0t: result with no request pending, expected none, got %p", $time, got);
		end else begin
			want = expected_q.pop_front();
			compare_field("hit", 32'(want.hit), 32'(got.hit));
			compare_field("fault", 32'(want.fault), 32'(got.fault));
			compare_field("cold_fill", 32'(want.cold_fill), 32'(got.cold_fill));
			compare_field("frame_index", 32'(want.frame_index), 32'(got.frame_index));
			compare_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
			compare_field("fault_count", want.fault_count, got.fault_count);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q = POL_FIFO;
			frames_q = FRAME_COUNT_RESET;
			clear_table();
			expected_q.delete();
			fails = 0;
			seen_count = 0;
			errors <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_POLICY)
					policy_q = cfg_data[1:0];
				else if (cfg_index == REG_FRAME_COUNT)
					frames_q = cfg_data;
			end
			if (rsp_valid && !rsp_stall) begin
				check_result(rsp_data);
				seen_count++;
			end
			if (req_valid && !req_stall)
				expected_q.push_back(predict_access(req_data));
			// Requests still waiting for their result count against the run as well.
			errors <= fails + expected_q.size();
			results_seen <= seen_count;
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import prp_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 60;
	localparam int IDLE_PERCENT  = 37;

	localparam logic       ACT_ACCESS = 1'b0;
	localparam logic [1:0] POL_SPARE  = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	prp_req_t              req_data = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	prp_rsp_t              rsp_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int   errors;
	int   results_seen;
	int   sent = 0;
	int   cycles = 0;
	int   hold_count = 0;
	logic calm = 1'b0;
	logic hold_req = 1'b0;

	logic [15:0] page_pool [12];
	int          pool_size;

	always #5 clk = ~clk;

	page_replacement_policy uut (.*);

	prp_checker access_check (.*);

	always @(posedge clk) begin
		if (hold_req && hold_count < HOLD_CYCLES) begin
			rsp_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_request(input logic act, input logic [15:0] page);
		prp_req_t r;
		r.action = act;
		r.page_number = page;
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_seen != sent);
	endtask

	task automatic configure(input logic [1:0] pol, input logic [3:0] frames);
		cfg_we <= 1'b1;
		cfg_index <= REG_POLICY;
		cfg_data <= {2'b00, pol};
		@(posedge clk);
		cfg_index <= REG_FRAME_COUNT;
		cfg_data <= frames;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [1:0]  pol;
		logic [3:0]  frames;
		logic [15:0] page;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: FIFO over eight frames, extreme page numbers and a clear.
		send_request(ACT_ACCESS, 16'h0000);
		send_request(ACT_ACCESS, 16'hFFFF);
		send_request(ACT_ACCESS, 16'h0000);
		send_request(ACT_CLEAR, 16'hFFFF);
		send_request(ACT_ACCESS, 16'hFFFF);

		drain();
		configure(POL_CLOCK, 4'd2);
		send_request(ACT_CLEAR, 16'h0000);
		send_request(ACT_ACCESS, 16'h0001);
		send_request(ACT_ACCESS, 16'h0002);
		send_request(ACT_ACCESS, 16'h0001);
		send_request(ACT_ACCESS, 16'h0003);
		send_request(ACT_ACCESS, 16'h0002);
		send_request(ACT_ACCESS, 16'h0001);

		// A frame count of zero acts as one, below the two frames already resident.
		drain();
		configure(POL_LRU, 4'd0);
		send_request(ACT_ACCESS, 16'h0005);
		send_request(ACT_ACCESS, 16'h0005);
		send_request(ACT_ACCESS, 16'h0006);
		send_request(ACT_ACCESS, 16'h0005);

		drain();
		configure(POL_SPARE, 4'd15);
		send_request(ACT_CLEAR, 16'h5A5A);
		for (int i = 0; i < 8; i++)
			send_request(ACT_ACCESS, 16'(16'h1111 * (i + 1)));

		drain();
		configure(POL_FIFO, 4'd2);
		send_request(ACT_ACCESS, 16'hA5A5);
		send_request(ACT_ACCESS, 16'h4444);

		for (int ph = 0; ph < PHASES; ph++) begin
			pol = (ph < 9) ? 2'(ph % 3) : 2'($urandom_range(3));
			case (ph % 4)
				0: frames = 4'd1;
				1: frames = 4'd8;
				default: frames = 4'($urandom_range(15));
			endcase
			drain();
			calm <= (ph == 4);
			if (ph == 6)
				hold_req <= 1'b1;
			configure(pol, frames);
			pool_size = ((frames == 0) ? 1 : ((frames > 8) ? 8 : frames)) + $urandom_range(4);
			for (int i = 0; i < pool_size; i++)
				page_pool[i] = 16'($urandom);
			if (ph == 0 || $urandom_range(3) != 0)
				send_request(ACT_CLEAR, 16'($urandom));
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(99) < 85)
					page = page_pool[$urandom_range(pool_size - 1)];
				else
					page = 16'($urandom);
				if ($urandom_range(99) < 3)
					send_request(ACT_CLEAR, page);
				else
					send_request(ACT_ACCESS, page);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
